// ===== hdl/sia_pkg.sv =====
// Shared constants, codes, types and saturation helper for the saturating ALU.
package sia_pkg;

    // Operand width used inside the block; port fields stay 32 bits.
    localparam int DATA_WIDTH = 32;
    localparam int PORT_WIDTH = 32;
    localparam int WIDE_WIDTH = 64;
    localparam int SHAMT_WIDTH = 6;

    // Queue between the front and back parts.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    localparam logic signed [WIDE_WIDTH-1:0] SAT_MAX =
        (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    localparam logic signed [WIDE_WIDTH-1:0] SAT_MIN = -SAT_MAX - 64'sd1;

    typedef logic [DATA_WIDTH-1:0] t_data;

    typedef enum logic [3:0] {
        KIND_NONE = 4'd0,
        KIND_ADD  = 4'd1,
        KIND_SUB  = 4'd2,
        KIND_MUL  = 4'd3,
        KIND_DIV  = 4'd4,
        KIND_MOD  = 4'd5,
        KIND_OR   = 4'd6,
        KIND_AND  = 4'd7,
        KIND_XOR  = 4'd8,
        KIND_SHL  = 4'd9,
        KIND_SHR  = 4'd10
    } t_kind;

    // What the back part still has to do with a transaction.
    typedef enum logic [1:0] {
        CLS_DONE = 2'd0,
        CLS_MUL  = 2'd1,
        CLS_DIV  = 2'd2,
        CLS_MOD  = 2'd3
    } t_cls;

    // Classified transaction handed from front to back through the queue.
    typedef struct packed {
        t_cls  cls;
        logic  bad;
        t_data res;
        t_data a;
        t_data b;
    } t_work;

    // Saturate a 64-bit signed value to the DATA_WIDTH range.
    function automatic t_data sat64(input logic signed [WIDE_WIDTH-1:0] v);
        logic signed [WIDE_WIDTH-1:0] c;
        begin
            c = v;
            if (v > SAT_MAX) begin
                c = SAT_MAX;
            end else if (v < SAT_MIN) begin
                c = SAT_MIN;
            end
            return c[DATA_WIDTH-1:0];
        end
    endfunction

endpackage

// ===== hdl/sia_in_if.sv =====
// Input channel: opcode and two operands with valid/ready.
interface sia_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [31:0] operand_a;
    logic [31:0] operand_b;

    modport source (output valid, output kind, output operand_a, output operand_b,
                    input ready);
    modport sink (input valid, input kind, input operand_a, input operand_b,
                  output ready);
endinterface

// ===== hdl/sia_out_if.sv =====
// Output channel: saturated result and bad opcode flag with valid/ready.
interface sia_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;
    logic        bad_op;

    modport source (output valid, output result, output bad_op, input ready);
    modport sink (input valid, input result, input bad_op, output ready);
endinterface

// ===== hdl/sia_front.sv =====
// Front part: accepts transactions, decodes the opcode, finishes the simple ops.
module sia_front import sia_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sia_in_if.sink     i_in,
    input  logic       i_full,
    output logic       o_push,
    output t_work      o_work
);

    logic                          r_vld;
    t_work                         r_work;
    t_work                         n_work;
    t_data                         a;
    t_data                         b;
    logic signed [WIDE_WIDTH-1:0]  a64;
    logic signed [WIDE_WIDTH-1:0]  b64;
    logic signed [WIDE_WIDTH-1:0]  shl_v;
    logic signed [WIDE_WIDTH-1:0]  shr_v;
    logic                          cnt_ok;
    logic [SHAMT_WIDTH-1:0]        shamt;

    assign o_push   = r_vld && !i_full;
    assign i_in.ready = !r_vld || !i_full;
    assign o_work   = r_work;

    // Decode and simple datapath
    always_comb begin
        a      = i_in.operand_a[DATA_WIDTH-1:0];
        b      = i_in.operand_b[DATA_WIDTH-1:0];
        a64    = WIDE_WIDTH'(signed'(a));
        b64    = WIDE_WIDTH'(signed'(b));
        cnt_ok = !b[DATA_WIDTH-1] && (b[DATA_WIDTH-2:SHAMT_WIDTH] == '0);
        shamt  = b[SHAMT_WIDTH-1:0];
        shl_v  = a64 <<< shamt;
        shr_v  = a64 >>> shamt;

        n_work     = '0;
        n_work.a   = a;
        n_work.b   = b;
        n_work.cls = CLS_DONE;
        case (t_kind'(i_in.kind))
            KIND_ADD: n_work.res = sat64(a64 + b64);
            KIND_SUB: n_work.res = sat64(a64 - b64);
            KIND_MUL: n_work.cls = CLS_MUL;
            KIND_DIV: n_work.cls = CLS_DIV;
            KIND_MOD: n_work.cls = CLS_MOD;
            KIND_OR:  n_work.res = a | b;
            KIND_AND: n_work.res = a & b;
            KIND_XOR: n_work.res = a ^ b;
            KIND_SHL: n_work.res = cnt_ok ? sat64(shl_v) : '0;
            KIND_SHR: n_work.res = cnt_ok ? shr_v[DATA_WIDTH-1:0] : {DATA_WIDTH{a[DATA_WIDTH-1]}};
            default: begin
                n_work.bad = 1'b1;
                n_work.res = '0;
            end
        endcase
    end

    // Holding register toward the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_vld <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_work <= n_work;
        end
    end

endmodule

// ===== hdl/sia_fifo.sv =====
// Short queue of classified transactions between front and back.
module sia_fifo import sia_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_work o_work
);

    t_work                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_AW:0]     r_cnt;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_work  = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(i_pop);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("queue count beyond depth");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");
`endif

endmodule

// ===== hdl/sia_back.sv =====
// Back part: multiplier, pipelined radix-2 divider and output register.
module sia_back import sia_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_work     i_work,
    output logic      o_pop,
    sia_out_if.source o_out
);

    localparam int NSTG = DATA_WIDTH + 1;

    typedef struct packed {
        t_cls  cls;
        logic  bad;
        logic  zdiv;
        logic  neg_q;
        logic  neg_r;
        t_data res;
        t_data a;
        t_data rem;
        t_data quo;
        t_data dvs;
    } t_stg;

    t_stg                             r_pipe [NSTG];
    t_stg                             n_pipe [NSTG];
    logic [NSTG-1:0]                  r_vld;
    logic signed [2*DATA_WIDTH-1:0]   r_prod;
    logic signed [2*DATA_WIDTH-1:0]   n_prod;
    logic                             r_ovld;
    t_data                            r_res;
    logic                             r_bad;
    t_data                            n_res;
    logic                             en;
    logic [DATA_WIDTH:0]              rem_sh;
    logic [DATA_WIDTH:0]              diff;
    t_stg                             last;

    assign en          = !r_ovld || o_out.ready;
    assign o_pop       = en && !i_empty;
    assign o_out.valid = r_ovld;
    assign o_out.result = PORT_WIDTH'(signed'(r_res));
    assign o_out.bad_op = r_bad;

    // Stage load, one quotient bit per stage, final sign fix and saturation
    always_comb begin
        n_pipe[0]       = '0;
        n_pipe[0].cls   = i_work.cls;
        n_pipe[0].bad   = i_work.bad;
        n_pipe[0].res   = i_work.res;
        n_pipe[0].a     = i_work.a;
        n_pipe[0].zdiv  = (i_work.b == '0);
        n_pipe[0].neg_q = i_work.a[DATA_WIDTH-1] ^ i_work.b[DATA_WIDTH-1];
        n_pipe[0].neg_r = i_work.a[DATA_WIDTH-1];
        n_pipe[0].quo   = i_work.a[DATA_WIDTH-1] ? -i_work.a : i_work.a;
        n_pipe[0].dvs   = i_work.b[DATA_WIDTH-1] ? -i_work.b : i_work.b;
        n_pipe[0].rem   = '0;
        n_prod          = signed'(i_work.a) * signed'(i_work.b);

        rem_sh = '0;
        diff   = '0;
        for (int k = 0; k < NSTG - 1; k++) begin
            n_pipe[k+1] = r_pipe[k];
            rem_sh      = {r_pipe[k].rem, r_pipe[k].quo[DATA_WIDTH-1]};
            diff        = rem_sh - {1'b0, r_pipe[k].dvs};
            if (!diff[DATA_WIDTH]) begin
                n_pipe[k+1].rem = diff[DATA_WIDTH-1:0];
                n_pipe[k+1].quo = {r_pipe[k].quo[DATA_WIDTH-2:0], 1'b1};
            end else begin
                n_pipe[k+1].rem = rem_sh[DATA_WIDTH-1:0];
                n_pipe[k+1].quo = {r_pipe[k].quo[DATA_WIDTH-2:0], 1'b0};
            end
        end
        if (r_pipe[0].cls == CLS_MUL) begin
            n_pipe[1].res = sat64(WIDE_WIDTH'(r_prod));
        end

        last = r_pipe[NSTG-1];
        case (last.cls)
            CLS_DIV: n_res = last.zdiv ? last.a :
                sat64(last.neg_q ? -WIDE_WIDTH'(last.quo) : WIDE_WIDTH'(last.quo));
            CLS_MOD: n_res = last.zdiv ? last.a : (last.neg_r ? -last.rem : last.rem);
            default: n_res = last.res;
        endcase
    end

    // Pipeline registers, advanced together when the output can move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_vld  <= {r_vld[NSTG-2:0], !i_empty};
            r_ovld <= r_vld[NSTG-1];
        end
        if (en) begin
            for (int k = 0; k < NSTG; k++) begin
                r_pipe[k] <= n_pipe[k];
            end
            r_prod <= n_prod;
            r_res  <= n_res;
            r_bad  <= last.bad;
        end
    end

`ifndef SYNTHESIS
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_bad) |-> (r_res == '0)) else $error("bad opcode with nonzero result");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld)) else $error("pipeline moved while stalled");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_res)) else $error("result changed while stalled");
`endif

endmodule

// ===== hdl/saturating_integer_alu.sv =====
// Top level of the saturating integer ALU: front, queue and back part.
// One transaction in, one result out, in order; a new transaction is taken every
// clock cycle unless the queue is full or the output is not taken. A transaction
// passes one front register, the four-entry queue, a multiplier stage, one stage
// per quotient bit of the radix-2 divider, and the output register. All
// operations take the same path, so results leave in input order. Unknown
// opcodes give result 0 with bad_op set.
module saturating_integer_alu import sia_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sia_in_if.sink    i_in,
    sia_out_if.source o_out
);

    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    t_work front_work;
    t_work head_work;

    sia_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_work  (front_work)
    );

    sia_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (front_work),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_work  (head_work)
    );

    sia_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_work  (head_work),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
